@@ hw/rtl/ifc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifc_pkg
// Shared constants of the information frame checker: status codes, frame
// byte positions, payload types, register map and reset values.
// ----------------------------------------------------------------------------
package ifc_pkg;

   localparam int unsigned ByteW = 8;

   // frame status codes
   localparam logic [3:0] ST_OK      = 4'd0;
   localparam logic [3:0] ST_START   = 4'd1;
   localparam logic [3:0] ST_ADDRESS = 4'd2;
   localparam logic [3:0] ST_CONTROL = 4'd3;
   localparam logic [3:0] ST_BCC1    = 4'd4;
   localparam logic [3:0] ST_TYPE    = 4'd5;
   localparam logic [3:0] ST_BCC2    = 4'd6;
   localparam logic [3:0] ST_END     = 4'd7;
   localparam logic [3:0] ST_SHORT   = 4'd8;

   // byte position within the frame
   localparam logic [2:0] POS_FLAG    = 3'd0;
   localparam logic [2:0] POS_ADDRESS = 3'd1;
   localparam logic [2:0] POS_CONTROL = 3'd2;
   localparam logic [2:0] POS_BCC1    = 3'd3;
   localparam logic [2:0] POS_TYPE    = 3'd4;
   localparam logic [2:0] POS_HELD1   = 3'd5;
   localparam logic [2:0] POS_HELD2   = 3'd6;

   // payload types
   localparam logic [7:0] TYPE_DATA  = 8'd1;
   localparam logic [7:0] TYPE_START = 8'd2;
   localparam logic [7:0] TYPE_END   = 8'd3;

   // register map
   localparam logic REG_FLAG    = 1'b0;
   localparam logic REG_ADDRESS = 1'b1;

   localparam logic [7:0] FLAG_RESET    = 8'd126;
   localparam logic [7:0] ADDRESS_RESET = 8'd3;

endpackage : ifc_pkg
`default_nettype wire

@@ hw/rtl/information_frame_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// information_frame_checker
// Checks one destuffed information frame a byte at a time, passes the
// payload out two bytes late and reports frame status at the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one frame byte per item; tlast marks the frame's last byte.
//   rsp_*  : one item per payload byte passed out and/or per frame end.
//            tuser is payload_valid, tlast is frame_done. Bytes that give
//            no result (header, first two payload bytes) produce no item.
//   csr_*  : flag byte at 0x0, address byte at 0x4; write only while idle.
// After acceptance the item sits in the input register, and the compare/xor
// logic loads its result into the result register, which drives rsp_tvalid.
// One item is accepted per cycle while the result register is empty or being
// taken, which is also when the input register advances.
// When the receiver stalls, the result holds, the input register fills and
// then req_tready drops. Reset clears frame state, empties both registers
// and loads flag 0x7E and address 0x03.
// ----------------------------------------------------------------------------
module information_frame_checker
   import ifc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] rx_byte, [15:8] expected_control
   input  wire logic        req_tlast,   // last_byte
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] payload_out, [11:8] frame_status,
                                         // [13:12] frame_type, [15:14] zero
   output logic             rsp_tuser,   // payload_valid
   output logic             rsp_tlast,   // frame_done
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // configuration
   logic [7:0] flag_ff;
   logic [7:0] addr_cfg_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff     <= FLAG_RESET;
         addr_cfg_ff <= ADDRESS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            REG_FLAG:    flag_ff     <= csr_pwdata[7:0];
            REG_ADDRESS: addr_cfg_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FLAG:    csr_prdata = {24'd0, flag_ff};
         REG_ADDRESS: csr_prdata = {24'd0, addr_cfg_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // input register
   logic        in_vld_ff;
   logic [7:0]  rx_ff;
   logic [7:0]  ctrl_ff;
   logic        last_ff;
   logic        advance;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         rx_ff   <= req_tdata[7:0];
         ctrl_ff <= req_tdata[15:8];
         last_ff <= req_tlast;
      end
   end

   // frame state
   logic [2:0] pos_ff,  pos_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] ctl_ff,  ctl_in;
   logic [3:0] err_ff,  err_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] xor_ff,  xor_in;
   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;

   // result of the current item
   logic       pv;
   logic [7:0] pb;
   logic       done;
   logic [3:0] status;
   logic [1:0] kind;
   logic [7:0] xr;
   logic [3:0] e;

   always_comb begin
      pos_in   = pos_ff;
      addr_in  = addr_ff;
      ctl_in   = ctl_ff;
      err_in   = err_ff;
      kind_in  = kind_ff;
      xor_in   = xor_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      pv       = 1'b0;
      pb       = '0;
      done     = 1'b0;
      status   = ST_OK;
      kind     = '0;
      xr       = xor_ff ^ held0_ff;
      e        = err_ff;

      if (last_ff && pos_ff < POS_HELD2) begin
         // frame ended early
         done   = 1'b1;
         status = (err_ff != ST_OK) ? err_ff : ST_SHORT;
         kind   = kind_ff;
      end else if (last_ff) begin
         // held0 is the final payload byte, held1 is BCC2, rx is the flag
         pv = 1'b1;
         pb = held0_ff;
         if (e == ST_OK && held1_ff != xr) begin
            e = ST_BCC2;
         end
         if (e == ST_OK && rx_ff != flag_ff) begin
            e = ST_END;
         end
         done   = 1'b1;
         status = e;
         kind   = kind_ff;
      end else begin
         unique case (pos_ff)
            POS_FLAG: begin
               if (rx_ff != flag_ff) begin
                  err_in = ST_START;
               end else begin
                  err_in = ST_OK;
               end
               addr_in  = '0;
               ctl_in   = '0;
               kind_in  = '0;
               xor_in   = '0;
               held0_in = '0;
               held1_in = '0;
               pos_in   = POS_ADDRESS;
            end
            POS_ADDRESS: begin
               addr_in = rx_ff;
               if (err_ff == ST_OK && rx_ff != addr_cfg_ff) begin
                  err_in = ST_ADDRESS;
               end
               pos_in = POS_CONTROL;
            end
            POS_CONTROL: begin
               ctl_in = rx_ff;
               if (err_ff == ST_OK && rx_ff != ctrl_ff) begin
                  err_in = ST_CONTROL;
               end
               pos_in = POS_BCC1;
            end
            POS_BCC1: begin
               if (err_ff == ST_OK && rx_ff != (addr_ff ^ ctl_ff)) begin
                  err_in = ST_BCC1;
               end
               pos_in = POS_TYPE;
            end
            POS_TYPE: begin
               if (rx_ff == TYPE_DATA || rx_ff == TYPE_START || rx_ff == TYPE_END) begin
                  kind_in = rx_ff[1:0];
               end else begin
                  kind_in = '0;
                  if (err_ff == ST_OK) begin
                     err_in = ST_TYPE;
                  end
               end
               held0_in = rx_ff;
               pos_in   = POS_HELD1;
            end
            POS_HELD1: begin
               held1_in = rx_ff;
               pos_in   = POS_HELD2;
            end
            default: begin
               // shift the delay line and pass the oldest byte out
               pv       = 1'b1;
               pb       = held0_ff;
               xor_in   = xr;
               held0_in = held1_ff;
               held1_in = rx_ff;
               pos_in   = POS_HELD2;
            end
         endcase
      end

      if (last_ff) begin
         // clear for the next frame
         pos_in   = POS_FLAG;
         addr_in  = '0;
         ctl_in   = '0;
         err_in   = ST_OK;
         kind_in  = '0;
         xor_in   = '0;
         held0_in = '0;
         held1_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_FLAG;
         addr_ff  <= '0;
         ctl_ff   <= '0;
         err_ff   <= ST_OK;
         kind_ff  <= '0;
         xor_ff   <= '0;
         held0_ff <= '0;
         held1_ff <= '0;
      end else if (advance && in_vld_ff) begin
         pos_ff   <= pos_in;
         addr_ff  <= addr_in;
         ctl_ff   <= ctl_in;
         err_ff   <= err_in;
         kind_ff  <= kind_in;
         xor_ff   <= xor_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
   end

   // result register
   logic        rsp_vld_ff;
   logic [15:0] rsp_data_ff;
   logic        rsp_user_ff;
   logic        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= in_vld_ff && (pv || done);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {2'b00, kind, status, pb};
         rsp_user_ff <= pv;
         rsp_last_ff <= done;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule : information_frame_checker
`default_nettype wire
